// ===== hw/rtl/lfu_ct_pkg.sv =====
// Shared types and constants for the LFU cache table.
package lfu_ct_pkg;

    localparam int unsigned FUNC_W  = 1;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned STAMP_W = 48;
    localparam int unsigned CAP_W   = 5;

    localparam logic [FUNC_W-1:0]  FUNC_GET = 1'b0;
    localparam logic [FUNC_W-1:0]  FUNC_PUT = 1'b1;

    localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
    localparam logic [STAMP_W-1:0] CLOCK_RESET = 48'd1;
    localparam logic [COUNT_W-1:0] COUNT_FIRST = 32'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

endpackage

// ===== hw/rtl/lfu_ct_req_if.sv =====
// Request channel: access function, key and value with valid/ready.
interface lfu_ct_req_if;
    logic                                valid;
    logic                                ready;
    logic [lfu_ct_pkg::FUNC_W-1:0]       func;
    logic [lfu_ct_pkg::KEY_W-1:0]        key;
    logic [lfu_ct_pkg::VALUE_W-1:0]      value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

// ===== hw/rtl/lfu_ct_rsp_if.sv =====
// Response channel: hit, read value and eviction report with valid/ready.
interface lfu_ct_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [lfu_ct_pkg::VALUE_W-1:0]      read_value;
    logic                                evicted;
    logic [lfu_ct_pkg::KEY_W-1:0]        evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

// ===== hw/rtl/lfu_cache_table_top.sv =====
// LFU cache table: fully associative key/value store, LFU eviction, LRU tie-break.
//
// Channels: req (func/key/value) in, rsp (hit/read_value/evicted/evicted_key)
// out, both valid/ready; a request is taken when valid and ready are high.
// cfg_wr_en/cfg_wr_data write the capacity register (write it only when idle).
// Each request, after acceptance, scans every table entry, then writes back:
// one table entry is read per cycle from the entry memory, the drain state
// finishes the last compare, and the write state writes back and loads the
// response register. The next request is taken in the cycle after that.
// A response held by a stalled receiver does not block the next request's
// scan; only its write-back waits until the response register is free.
// Reset clears all valid bits, sets capacity to 16, the use clock to 1 and
// the occupancy to 0; the block is ready right after reset.
// Capacity above ENTRIES acts as ENTRIES; zero capacity ignores new keys.
// Use counts saturate; the 48-bit use clock wraps.
module lfu_cache_table_top #(
    parameter int unsigned ENTRIES  = 16,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lfu_ct_pkg::CAP_W-1:0]      cfg_wr_data,
    lfu_ct_req_if.sink                        req,
    lfu_ct_rsp_if.source                      rsp
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W = (OCC_W > lfu_ct_pkg::CAP_W) ? OCC_W : lfu_ct_pkg::CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

    // entry memories, one write port and one registered read port
    logic [KEY_BITS-1:0]                key_mem   [ENTRIES];
    logic [lfu_ct_pkg::VALUE_W-1:0]     data_mem  [ENTRIES];
    logic [lfu_ct_pkg::COUNT_W-1:0]     count_mem [ENTRIES];
    logic [lfu_ct_pkg::STAMP_W-1:0]     stamp_mem [ENTRIES];

    logic [ENTRIES-1:0]                 valid_reg;
    logic [lfu_ct_pkg::CAP_W-1:0]       capacity_reg;
    logic [lfu_ct_pkg::STAMP_W-1:0]     clock_reg;
    logic [OCC_W-1:0]                   occupied_reg;

    lfu_ct_pkg::state_t                 state_reg, state_next;
    logic [IDX_W-1:0]                   scan_idx_reg;

    logic [lfu_ct_pkg::FUNC_W-1:0]      func_reg;
    logic [KEY_BITS-1:0]                key_reg;
    logic [lfu_ct_pkg::VALUE_W-1:0]     value_reg;

    // read stage
    logic                               rd_live_reg;
    logic [IDX_W-1:0]                   rd_idx_reg;
    logic [KEY_BITS-1:0]                rd_key_reg;
    logic [lfu_ct_pkg::VALUE_W-1:0]     rd_data_reg;
    logic [lfu_ct_pkg::COUNT_W-1:0]     rd_count_reg;
    logic [lfu_ct_pkg::STAMP_W-1:0]     rd_stamp_reg;

    // search results
    logic                               found_reg;
    logic [IDX_W-1:0]                   match_idx_reg;
    logic [lfu_ct_pkg::VALUE_W-1:0]     match_data_reg;
    logic [lfu_ct_pkg::COUNT_W-1:0]     match_count_reg;
    logic                               have_vict_reg;
    logic [IDX_W-1:0]                   vict_idx_reg;
    logic [KEY_BITS-1:0]                vict_key_reg;
    logic [lfu_ct_pkg::COUNT_W-1:0]     vict_count_reg;
    logic [lfu_ct_pkg::STAMP_W-1:0]     vict_stamp_reg;
    logic                               have_free_reg;
    logic [IDX_W-1:0]                   free_idx_reg;

    // response register
    logic                               out_valid_reg;
    logic                               out_hit_reg;
    logic [lfu_ct_pkg::VALUE_W-1:0]     out_value_reg;
    logic                               out_evicted_reg;
    logic [lfu_ct_pkg::KEY_W-1:0]       out_evict_key_reg;

    // control
    logic                               accept;
    logic                               scan_en;
    logic                               wr_slot;
    logic                               rd_entry_valid;
    logic                               is_match;
    logic                               is_better;

    // write-back decision
    logic                               do_write;
    logic                               do_alloc;
    logic                               do_evict;
    logic [IDX_W-1:0]                   wr_idx;
    logic [lfu_ct_pkg::VALUE_W-1:0]     wr_data;
    logic [lfu_ct_pkg::COUNT_W-1:0]     wr_count;
    logic [CMP_W-1:0]                   cap_eff;
    logic [CMP_W-1:0]                   occ_ext;
    logic                               resp_hit;
    logic [lfu_ct_pkg::VALUE_W-1:0]     resp_value;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfu_ct_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = lfu_ct_pkg::ST_SCAN;
                end
            end
            lfu_ct_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = lfu_ct_pkg::ST_DRAIN;
                end
            end
            lfu_ct_pkg::ST_DRAIN:
            begin
                state_next = lfu_ct_pkg::ST_WRITE;
            end
            lfu_ct_pkg::ST_WRITE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = lfu_ct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_ct_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req.ready = 1'b0;
        scan_en   = 1'b0;
        wr_slot   = 1'b0;
        unique case (state_reg)
            lfu_ct_pkg::ST_IDLE:  req.ready = 1'b1;
            lfu_ct_pkg::ST_SCAN:  scan_en   = 1'b1;
            lfu_ct_pkg::ST_DRAIN: ;
            lfu_ct_pkg::ST_WRITE: wr_slot   = !out_valid_reg || rsp.ready;
            default: ;
        endcase
    end

    assign accept = req.valid && req.ready;

    // compare stage
    assign rd_entry_valid = rd_live_reg && valid_reg[rd_idx_reg];
    assign is_match       = rd_entry_valid && (rd_key_reg == key_reg);
    assign is_better      = rd_entry_valid &&
                            (!have_vict_reg || (rd_count_reg < vict_count_reg) ||
                             ((rd_count_reg == vict_count_reg) &&
                              (rd_stamp_reg < vict_stamp_reg)));

    // write-back decision
    always_comb
    begin
        cap_eff = CMP_W'(capacity_reg);
        if (cap_eff > ENTRIES_C)
        begin
            cap_eff = ENTRIES_C;
        end
        occ_ext    = CMP_W'(occupied_reg);
        do_write   = 1'b0;
        do_alloc   = 1'b0;
        do_evict   = 1'b0;
        wr_idx     = match_idx_reg;
        wr_data    = value_reg;
        wr_count   = lfu_ct_pkg::COUNT_FIRST;
        resp_hit   = 1'b0;
        resp_value = '0;
        priority if (found_reg)
        begin
            do_write = 1'b1;
            resp_hit = 1'b1;
            wr_count = (match_count_reg == lfu_ct_pkg::COUNT_MAX) ?
                       match_count_reg : match_count_reg + 1'b1;
            if (func_reg == lfu_ct_pkg::FUNC_GET)
            begin
                wr_data    = match_data_reg;
                resp_value = match_data_reg;
            end
        end
        else if (func_reg == lfu_ct_pkg::FUNC_GET || cap_eff == '0)
        begin
            // miss on get, or nothing may be stored: no change
        end
        else if (occ_ext >= cap_eff && have_vict_reg)
        begin
            do_write = 1'b1;
            do_evict = 1'b1;
            wr_idx   = vict_idx_reg;
        end
        else if (have_free_reg)
        begin
            do_write = 1'b1;
            do_alloc = 1'b1;
            wr_idx   = free_idx_reg;
        end
        else
        begin
            // no slot picked yet: no change
        end
    end

    // memory write and read
    always_ff @(posedge clk)
    begin
        if (wr_slot && do_write)
        begin
            key_mem[wr_idx]   <= key_reg;
            data_mem[wr_idx]  <= wr_data;
            count_mem[wr_idx] <= wr_count;
            stamp_mem[wr_idx] <= clock_reg;
        end
        if (scan_en)
        begin
            rd_key_reg   <= key_mem[scan_idx_reg];
            rd_data_reg  <= data_mem[scan_idx_reg];
            rd_count_reg <= count_mem[scan_idx_reg];
            rd_stamp_reg <= stamp_mem[scan_idx_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= req.func;
            key_reg   <= KEY_BITS'(req.key);
            value_reg <= req.value;
        end
        rd_idx_reg <= scan_idx_reg;
        if (is_match && !found_reg)
        begin
            match_idx_reg   <= rd_idx_reg;
            match_data_reg  <= rd_data_reg;
            match_count_reg <= rd_count_reg;
        end
        if (is_better)
        begin
            vict_idx_reg   <= rd_idx_reg;
            vict_key_reg   <= rd_key_reg;
            vict_count_reg <= rd_count_reg;
            vict_stamp_reg <= rd_stamp_reg;
        end
        if (rd_live_reg && !valid_reg[rd_idx_reg] && !have_free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (wr_slot)
        begin
            out_hit_reg       <= resp_hit;
            out_value_reg     <= resp_value;
            out_evicted_reg   <= do_evict;
            out_evict_key_reg <= do_evict ? lfu_ct_pkg::KEY_W'(vict_key_reg) : '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfu_ct_pkg::ST_IDLE;
            scan_idx_reg  <= '0;
            rd_live_reg   <= 1'b0;
            found_reg     <= 1'b0;
            have_vict_reg <= 1'b0;
            have_free_reg <= 1'b0;
            valid_reg     <= '0;
            capacity_reg  <= lfu_ct_pkg::CAP_RESET;
            clock_reg     <= lfu_ct_pkg::CLOCK_RESET;
            occupied_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_live_reg <= scan_en;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                scan_idx_reg  <= '0;
                found_reg     <= 1'b0;
                have_vict_reg <= 1'b0;
                have_free_reg <= 1'b0;
            end
            else
            begin
                if (scan_en)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (is_match)
                begin
                    found_reg <= 1'b1;
                end
                if (is_better)
                begin
                    have_vict_reg <= 1'b1;
                end
                if (rd_live_reg && !valid_reg[rd_idx_reg])
                begin
                    have_free_reg <= 1'b1;
                end
            end
            if (wr_slot && do_write)
            begin
                valid_reg[wr_idx] <= 1'b1;
                clock_reg         <= clock_reg + 1'b1;
            end
            if (wr_slot && do_alloc)
            begin
                occupied_reg <= occupied_reg + 1'b1;
            end
            // hold the response until taken, reload on write-back
            if (wr_slot)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.evicted     = out_evicted_reg;
    assign rsp.evicted_key = out_evict_key_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LFU cache table: access predictor, directed and random requests.
module tb_top;
    import lfu_ct_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 16;
    localparam int unsigned DRAIN_CYCLES  = TABLE_ENTRIES + 3;
    localparam int unsigned CYCLE_LIMIT   = 800000;
    localparam int unsigned PHASE_ITEMS   = 185;
    localparam int unsigned HOLD_CYCLES   = 300;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } access_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CAP_W-1:0]   cfg_wr_data;

    lfu_ct_req_if req_ch();
    lfu_ct_rsp_if rsp_ch();

    lfu_cache_table_top #(
        .ENTRIES  (TABLE_ENTRIES),
        .KEY_BITS (KEY_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Predictor state: one copy of the table and its bookkeeping.
    logic                 tbl_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]     tbl_key   [TABLE_ENTRIES];
    logic [VALUE_W-1:0]   tbl_data  [TABLE_ENTRIES];
    logic [COUNT_W-1:0]   tbl_count [TABLE_ENTRIES];
    logic [STAMP_W-1:0]   tbl_stamp [TABLE_ENTRIES];
    logic [STAMP_W-1:0]   use_clock;
    int unsigned          fill_level;
    logic [CAP_W-1:0]     cap_reg;

    access_result_t       pending_results [$];
    logic [KEY_W-1:0]     key_pool [$];
    int unsigned          error_count;
    int unsigned          stall_left;
    int unsigned          hold_request;
    int unsigned          cycle_count;
    bit                   gaps_on;

    function automatic void place_entry(input int idx, input logic [KEY_W-1:0] key,
                                        input logic [VALUE_W-1:0] value);
        tbl_valid[idx] = 1'b1;
        tbl_key[idx]   = key;
        tbl_data[idx]  = value;
        tbl_count[idx] = COUNT_FIRST;
        tbl_stamp[idx] = use_clock;
        use_clock      = use_clock + 1'b1;
    endfunction

    function automatic access_result_t predict_access(input logic [FUNC_W-1:0] func,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [VALUE_W-1:0] value);
        access_result_t res;
        int             slot;
        bit             found;
        bit             have;
        int unsigned    limit;
        res   = '0;
        slot  = 0;
        found = 1'b0;
        have  = 1'b0;
        limit = (cap_reg > TABLE_ENTRIES) ? TABLE_ENTRIES : cap_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!found && tbl_valid[i] && tbl_key[i] == key)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            res.hit = 1'b1;
            if (func == FUNC_PUT)
                tbl_data[slot] = value;
            else
                res.read_value = tbl_data[slot];
            if (tbl_count[slot] != COUNT_MAX)
                tbl_count[slot] = tbl_count[slot] + 1'b1;
            tbl_stamp[slot] = use_clock;
            use_clock = use_clock + 1'b1;
            return res;
        end
        if (func == FUNC_GET || limit == 0)
            return res;
        if (fill_level >= limit)
        begin
            // lowest count wins, oldest stamp breaks ties, lowest index last
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (tbl_valid[i] && (!have || tbl_count[i] < tbl_count[slot] ||
                    (tbl_count[i] == tbl_count[slot] && tbl_stamp[i] < tbl_stamp[slot])))
                begin
                    slot = i;
                    have = 1'b1;
                end
            end
            if (have)
            begin
                res.evicted     = 1'b1;
                res.evicted_key = tbl_key[slot];
                place_entry(slot, key, value);
                return res;
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!tbl_valid[i])
            begin
                place_entry(i, key, value);
                fill_level++;
                return res;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    // Call at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.func  = func;
        req_ch.key   = key;
        req_ch.value = value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(predict_access(func, key, value));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = cap;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cap_reg     = cap;
    endtask

    task automatic refill_pool(input int unsigned n);
        key_pool.delete();
        repeat (n) key_pool.push_back($urandom);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return roll[0] ? '1 : '0;
        if (roll < 15)
            return $urandom;
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return roll[0] ? '1 : '0;
        return $urandom;
    endfunction

    task automatic test_basic_access();
        send_request(FUNC_GET, 32'h0000_0000, 32'h1111_1111);
        send_request(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_GET, 32'h0000_0005, 32'h0000_0000);
    endtask

    task automatic test_eviction();
        write_capacity(5'd2);
        send_request(FUNC_PUT, 32'hA5A5_0001, 32'h0000_00A1);
        send_request(FUNC_PUT, 32'hA5A5_0002, 32'h0000_00A2);
        send_request(FUNC_GET, 32'hA5A5_0002, 32'h0000_0000);
        send_request(FUNC_PUT, 32'hA5A5_0003, 32'h0000_00A3);
        send_request(FUNC_PUT, 32'hA5A5_0004, 32'h0000_00A4);
    endtask

    task automatic test_zero_capacity();
        write_capacity(5'd0);
        send_request(FUNC_PUT, 32'h5A5A_0001, 32'hDEAD_BEEF);
        send_request(FUNC_GET, 32'h5A5A_0001, 32'h0000_0000);
        send_request(FUNC_PUT, 32'hA5A5_0004, 32'hCAFE_F00D);
        send_request(FUNC_GET, 32'hA5A5_0004, 32'h0000_0000);
    endtask

    task automatic test_shrink();
        write_capacity(5'd31);
        send_request(FUNC_PUT, 32'h0F0F_0001, 32'h8000_0000);
        send_request(FUNC_PUT, 32'h0F0F_0002, 32'h0000_0001);
        send_request(FUNC_PUT, 32'h0F0F_0003, 32'h7FFF_FFFF);
        // occupancy now exceeds the new capacity: each new key evicts
        write_capacity(5'd1);
        send_request(FUNC_PUT, 32'h0F0F_0004, 32'h0000_0004);
        send_request(FUNC_PUT, 32'h0F0F_0005, 32'h0000_0005);
    endtask

    task automatic test_random_mix();
        int unsigned cap_plan [10];
        int unsigned eff;
        cap_plan = '{16, 1, 5, 0, 31, 8, 17, 3, 16, 12};
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(cap_plan[p][CAP_W-1:0]);
            gaps_on = (p % 3) != 2;
            eff = (cap_plan[p] > TABLE_ENTRIES) ? TABLE_ENTRIES : cap_plan[p];
            refill_pool(eff + 4);
            repeat (PHASE_ITEMS)
                send_request($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET, pick_key(), pick_value());
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_capacity(CAP_RESET);
        gaps_on = 1'b0;
        refill_pool(20);
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        @(negedge clk);
        repeat (30)
            send_request($urandom_range(0, 3) != 0 ? FUNC_PUT : FUNC_GET, pick_key(), pick_value());
        gaps_on = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Response ready: per-response stall draws, plus a long hold when requested.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        access_result_t exp_res;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                exp_res = pending_results.pop_front();
                if (rsp_ch.hit !== exp_res.hit)
                    report_mismatch($sformatf("hit got %b expected %b",
                                              rsp_ch.hit, exp_res.hit));
                if (rsp_ch.read_value !== exp_res.read_value)
                    report_mismatch($sformatf("read_value got %h expected %h",
                                              rsp_ch.read_value, exp_res.read_value));
                if (rsp_ch.evicted !== exp_res.evicted)
                    report_mismatch($sformatf("evicted got %b expected %b",
                                              rsp_ch.evicted, exp_res.evicted));
                if (rsp_ch.evicted_key !== exp_res.evicted_key)
                    report_mismatch($sformatf("evicted_key got %h expected %h",
                                              rsp_ch.evicted_key, exp_res.evicted_key));
            end
            stall_left = gaps_on ? $urandom_range(0, 15) : 0;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_GET;
        req_ch.key   = '0;
        req_ch.value = '0;
        error_count  = 0;
        stall_left   = 0;
        hold_request = 0;
        gaps_on      = 1'b1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_data[i]  = '0;
            tbl_count[i] = '0;
            tbl_stamp[i] = '0;
        end
        use_clock  = CLOCK_RESET;
        fill_level = 0;
        cap_reg    = CAP_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_access();
        test_eviction();
        test_zero_capacity();
        test_shrink();
        test_backpressure();
        test_random_mix();
        wait_idle();

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
